>>> sv/assert_macros.svh
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define Q4KBD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define Q4KBD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define Q4KBD_ASSERT(lbl, clk, rst, prop, msg)
`define Q4KBD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> sv/q4kbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// q4kbd_pkg
// Shared types and constants of the Q4_K super-block dequantizer.
// ----------------------------------------------------------------------------
package q4kbd_pkg;

   localparam logic [7:0] BLOCK_BYTES  = 8'd144;
   localparam logic [7:0] HEADER_BYTES = 8'd16;
   localparam logic [7:0] POS_D_LO     = 8'd0;
   localparam logic [7:0] POS_D_HI     = 8'd1;
   localparam logic [7:0] POS_M_LO     = 8'd2;
   localparam logic [7:0] POS_M_HI     = 8'd3;
   localparam logic [7:0] POS_PACKED   = 8'd4;
   localparam logic [31:0] CANON_NAN   = 32'h7FC00000;

   // one nibble byte with everything the back end needs from its block header
   typedef struct packed {
      logic [15:0] d_half;
      logic [15:0] m_half;
      logic [5:0]  sc_lo;
      logic [5:0]  mn_lo;
      logic [5:0]  sc_hi;
      logic [5:0]  mn_hi;
      logic [7:0]  data;
      logic [1:0]  chunk;
      logic [4:0]  lane;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

endpackage
`default_nettype wire

>>> sv/q4kbd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// q4kbd_req_if / q4kbd_rsp_if
// Valid/ready channels for block bytes in and dequantized values out.
// ----------------------------------------------------------------------------
interface q4kbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       block_start;
   modport source (output valid, output data_byte, output block_start, input ready);
   modport sink   (input valid, input data_byte, input block_start, output ready);
endinterface

interface q4kbd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  element_index;
   logic [31:0] value_bits;
   logic        run_last;
   modport source (output valid, output element_index, output value_bits,
                   output run_last, input ready);
   modport sink   (input valid, input element_index, input value_bits,
                   input run_last, output ready);
endinterface
`default_nettype wire

>>> sv/q4kbd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// q4kbd_front
// Tracks the byte position, stores header fields, turns nibble bytes into
// queue entries with their decoded scale and min values.
// ----------------------------------------------------------------------------
module q4kbd_front (
   input  wire logic               clock,
   input  wire logic               reset,
   q4kbd_req_if.sink               req_ch,
   output q4kbd_pkg::push_type     push,
   input  wire logic               full
);

   logic [7:0]  pos_ff, pos_in;
   logic [7:0]  pos;
   logic [7:0]  pos_nxt;
   logic [15:0] d_ff, m_ff;
   logic [7:0]  q_ff [12];
   logic        take;
   logic [7:0]  k;
   logic [11:0] scmn_lo, scmn_hi;

   function automatic logic [11:0] scale_min(input logic [7:0] b [12], input logic [2:0] j);
      logic [3:0] jl;
      logic [5:0] sc, mn;
      jl = {2'b00, j[1:0]};
      if (!j[2]) begin
         sc = b[jl][5:0];
         mn = b[jl + 4'd4][5:0];
      end else begin
         sc = {b[jl][7:6], b[jl + 4'd8][3:0]};
         mn = {b[jl + 4'd4][7:6], b[jl + 4'd8][7:4]};
      end
      return {sc, mn};
   endfunction

   assign req_ch.ready = !full;
   assign take = req_ch.valid && !full;
   assign pos  = req_ch.block_start ? 8'd0 : pos_ff;
   assign k    = pos - q4kbd_pkg::HEADER_BYTES;
   assign pos_nxt = (pos + 8'd1 >= q4kbd_pkg::BLOCK_BYTES) ? 8'd0 : pos + 8'd1;
   assign pos_in  = take ? pos_nxt : pos_ff;

   assign scmn_lo = scale_min(q_ff, {k[6:5], 1'b0});
   assign scmn_hi = scale_min(q_ff, {k[6:5], 1'b1});

   always_comb begin
      push.valid        = take && (pos >= q4kbd_pkg::HEADER_BYTES);
      push.entry.d_half = d_ff;
      push.entry.m_half = m_ff;
      push.entry.sc_lo  = scmn_lo[11:6];
      push.entry.mn_lo  = scmn_lo[5:0];
      push.entry.sc_hi  = scmn_hi[11:6];
      push.entry.mn_hi  = scmn_hi[5:0];
      push.entry.data   = req_ch.data_byte;
      push.entry.chunk  = k[6:5];
      push.entry.lane   = k[4:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 8'd0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // header storage, no reset
   always_ff @(posedge clock) begin
      if (take) begin
         if (pos == q4kbd_pkg::POS_D_LO) d_ff[7:0]  <= req_ch.data_byte;
         if (pos == q4kbd_pkg::POS_D_HI) d_ff[15:8] <= req_ch.data_byte;
         if (pos == q4kbd_pkg::POS_M_LO) m_ff[7:0]  <= req_ch.data_byte;
         if (pos == q4kbd_pkg::POS_M_HI) m_ff[15:8] <= req_ch.data_byte;
         if (pos >= q4kbd_pkg::POS_PACKED && pos < q4kbd_pkg::HEADER_BYTES) begin
            q_ff[4'(pos - q4kbd_pkg::POS_PACKED)] <= req_ch.data_byte;
         end
      end
   end

endmodule
`default_nettype wire

>>> sv/q4kbd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// q4kbd_queue
// Two-entry queue between the byte front end and the arithmetic back end.
// ----------------------------------------------------------------------------
module q4kbd_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire q4kbd_pkg::push_type push,
   output logic                    full,
   output q4kbd_pkg::head_type     head,
   input  wire logic               pop
);

   q4kbd_pkg::entry_type mem_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_pop;

   assign full       = (cnt_ff == 2'd2);
   assign head.valid = (cnt_ff != 2'd0);
   assign head.entry = mem_ff[rd_ff];
   assign do_pop     = pop && head.valid;
   assign wr_in      = push.valid ? !wr_ff : wr_ff;
   assign rd_in      = do_pop ? !rd_ff : rd_ff;
   assign cnt_in     = cnt_ff + {1'b0, push.valid} - {1'b0, do_pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ff] <= push.entry;
      end
   end

endmodule
`default_nettype wire

>>> sv/q4kbd_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// q4kbd_back
// Five-stage pipeline: one value per cycle while the result channel is ready, low nibble then high nibble.
// Exact fixed-point difference of the two products, then one rounding.
// ----------------------------------------------------------------------------
module q4kbd_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire q4kbd_pkg::head_type head,
   output logic                    pop,
   q4kbd_rsp_if.source             rsp_ch
);

   logic en, issue;
   logic half_ff, half_in;

   // stage 1
   logic        s1_v_ff;
   logic [9:0]  s1_scn_ff;
   logic [5:0]  s1_mn_ff;
   logic [15:0] s1_d_ff, s1_m_ff;
   logic [7:0]  s1_idx_ff;
   logic        s1_last_ff;
   logic [5:0]  sc_sel, mn_sel;
   logic [3:0]  nib_sel;

   // stage 2
   logic        s2_v_ff;
   logic [20:0] s2_ma_ff;
   logic [16:0] s2_mb_ff;
   logic [4:0]  s2_sha_ff, s2_shb_ff;
   logic        s2_sa_ff, s2_sb_ff;
   logic        s2_anan_ff, s2_ainf_ff, s2_bnan_ff, s2_binf_ff;
   logic [7:0]  s2_idx_ff;
   logic        s2_last_ff;
   logic [10:0] md, mm;
   logic [4:0]  sha, shb;
   logic        d_nan, d_inf, m_nan, m_inf;

   // stage 3
   logic        s3_v_ff;
   logic [51:0] s3_n_ff;
   logic        s3_spec_ff;
   logic [31:0] s3_bits_ff;
   logic [7:0]  s3_idx_ff;
   logic        s3_last_ff;
   logic [51:0] a_al, b_al, a_sg, b_sg;
   logic        spec;
   logic [31:0] spec_bits;

   // stage 4
   logic        s4_v_ff;
   logic        s4_sign_ff;
   logic [50:0] s4_mag_ff;
   logic [5:0]  s4_p_ff;
   logic        s4_spec_ff;
   logic [31:0] s4_bits_ff;
   logic [7:0]  s4_idx_ff;
   logic        s4_last_ff;
   logic [51:0] nabs;
   logic [5:0]  lead;

   // output stage
   logic        out_v_ff;
   logic [31:0] out_bits_ff;
   logic [7:0]  out_idx_ff;
   logic        out_last_ff;
   logic [31:0] rnd_bits;
   logic [23:0] frac;
   logic [50:0] shr;
   logic [5:0]  rsh;
   logic        guard, sticky, up;
   logic [7:0]  expo;
   logic [30:0] body;

   assign en      = !out_v_ff || rsp_ch.ready;
   assign issue   = en && head.valid;
   assign pop     = issue && half_ff;
   assign half_in = issue ? !half_ff : half_ff;

   assign sc_sel  = half_ff ? head.entry.sc_hi : head.entry.sc_lo;
   assign mn_sel  = half_ff ? head.entry.mn_hi : head.entry.mn_lo;
   assign nib_sel = half_ff ? head.entry.data[7:4] : head.entry.data[3:0];

   // half decode: value = md * 2^(sh-24)
   always_comb begin
      md    = (s1_d_ff[14:10] == 5'd0) ? {1'b0, s1_d_ff[9:0]} : {1'b1, s1_d_ff[9:0]};
      sha   = (s1_d_ff[14:10] == 5'd0) ? 5'd0 : s1_d_ff[14:10] - 5'd1;
      d_nan = (s1_d_ff[14:10] == 5'h1F) && (s1_d_ff[9:0] != 10'd0);
      d_inf = (s1_d_ff[14:10] == 5'h1F) && (s1_d_ff[9:0] == 10'd0);
      mm    = (s1_m_ff[14:10] == 5'd0) ? {1'b0, s1_m_ff[9:0]} : {1'b1, s1_m_ff[9:0]};
      shb   = (s1_m_ff[14:10] == 5'd0) ? 5'd0 : s1_m_ff[14:10] - 5'd1;
      m_nan = (s1_m_ff[14:10] == 5'h1F) && (s1_m_ff[9:0] != 10'd0);
      m_inf = (s1_m_ff[14:10] == 5'h1F) && (s1_m_ff[9:0] == 10'd0);
   end

   // exact aligned difference and special values
   always_comb begin
      a_al = {31'd0, s2_ma_ff} << s2_sha_ff;
      b_al = {35'd0, s2_mb_ff} << s2_shb_ff;
      a_sg = s2_sa_ff ? -a_al : a_al;
      b_sg = s2_sb_ff ? -b_al : b_al;
      spec      = 1'b1;
      spec_bits = 32'd0;
      if (s2_anan_ff || s2_bnan_ff ||
          (s2_ainf_ff && s2_binf_ff && (s2_sa_ff == s2_sb_ff))) begin
         spec_bits = q4kbd_pkg::CANON_NAN;
      end else if (s2_ainf_ff) begin
         spec_bits = {s2_sa_ff, 8'hFF, 23'd0};
      end else if (s2_binf_ff) begin
         spec_bits = {!s2_sb_ff, 8'hFF, 23'd0};
      end else if (s2_ma_ff == 21'd0 && s2_mb_ff == 17'd0) begin
         spec_bits = {s2_sa_ff && !s2_sb_ff, 31'd0};
      end else begin
         spec = 1'b0;
      end
   end

   // leading one search
   always_comb begin
      nabs = s3_n_ff[51] ? -s3_n_ff : s3_n_ff;
      lead = 6'd0;
      for (int i = 0; i < 51; i++) begin
         if (nabs[i]) lead = 6'(i);
      end
   end

   // round to nearest even
   always_comb begin
      rsh    = 6'd0;
      shr    = s4_mag_ff;
      guard  = 1'b0;
      sticky = 1'b0;
      if (s4_p_ff <= 6'd23) begin
         frac = s4_mag_ff[23:0] << (6'd23 - s4_p_ff);
      end else begin
         rsh    = s4_p_ff - 6'd23;
         shr    = s4_mag_ff >> rsh;
         frac   = shr[23:0];
         guard  = s4_mag_ff[6'(rsh - 6'd1)];
         sticky = |(s4_mag_ff & ((51'd1 << (rsh - 6'd1)) - 51'd1));
      end
      up   = guard && (sticky || frac[0]);
      expo = {2'b00, s4_p_ff} + 8'd103;
      body = {expo, frac[22:0]} + {30'd0, up};
      if (s4_spec_ff) begin
         rnd_bits = s4_bits_ff;
      end else if (s4_mag_ff == 51'd0) begin
         rnd_bits = 32'd0;
      end else begin
         rnd_bits = {s4_sign_ff, body};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff  <= 1'b0;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         half_ff <= half_in;
         if (en) begin
            s1_v_ff  <= issue;
            s2_v_ff  <= s1_v_ff;
            s3_v_ff  <= s2_v_ff;
            s4_v_ff  <= s3_v_ff;
            out_v_ff <= s4_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_scn_ff  <= 10'(sc_sel * nib_sel);
         s1_mn_ff   <= mn_sel;
         s1_d_ff    <= head.entry.d_half;
         s1_m_ff    <= head.entry.m_half;
         s1_idx_ff  <= {head.entry.chunk, half_ff, head.entry.lane};
         s1_last_ff <= half_ff;

         s2_ma_ff   <= 21'(md * s1_scn_ff);
         s2_mb_ff   <= 17'(mm * s1_mn_ff);
         s2_sha_ff  <= sha;
         s2_shb_ff  <= shb;
         s2_sa_ff   <= s1_d_ff[15];
         s2_sb_ff   <= s1_m_ff[15];
         s2_anan_ff <= d_nan || (d_inf && s1_scn_ff == 10'd0);
         s2_ainf_ff <= d_inf && s1_scn_ff != 10'd0;
         s2_bnan_ff <= m_nan || (m_inf && s1_mn_ff == 6'd0);
         s2_binf_ff <= m_inf && s1_mn_ff != 6'd0;
         s2_idx_ff  <= s1_idx_ff;
         s2_last_ff <= s1_last_ff;

         s3_n_ff    <= a_sg - b_sg;
         s3_spec_ff <= spec;
         s3_bits_ff <= spec_bits;
         s3_idx_ff  <= s2_idx_ff;
         s3_last_ff <= s2_last_ff;

         s4_sign_ff <= s3_n_ff[51];
         s4_mag_ff  <= nabs[50:0];
         s4_p_ff    <= lead;
         s4_spec_ff <= s3_spec_ff;
         s4_bits_ff <= s3_bits_ff;
         s4_idx_ff  <= s3_idx_ff;
         s4_last_ff <= s3_last_ff;

         out_bits_ff <= rnd_bits;
         out_idx_ff  <= s4_idx_ff;
         out_last_ff <= s4_last_ff;
      end
   end

   assign rsp_ch.valid         = out_v_ff;
   assign rsp_ch.value_bits    = out_bits_ff;
   assign rsp_ch.element_index = out_idx_ff;
   assign rsp_ch.run_last      = out_last_ff;

   `Q4KBD_ASSERT(a_pop_second, clock, reset, pop |-> half_ff && head.valid, "pop before second value")
   `Q4KBD_ASSERT(a_half_hold, clock, reset, !issue |=> $stable(half_ff), "half toggled without issue")
   `Q4KBD_ASSERT(a_last_bit, clock, reset, out_v_ff |-> (out_last_ff == out_idx_ff[5]), "run_last mismatch")
   `Q4KBD_ASSERT(a_nan_canon, clock, reset, out_v_ff && out_bits_ff[30:23] == 8'hFF && out_bits_ff[22:0] != 23'd0 |-> out_bits_ff == q4kbd_pkg::CANON_NAN, "non-canonical nan")

endmodule
`default_nettype wire

>>> sv/q4_k_block_dequantizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// q4_k_block_dequantizer
// Dequantizes a byte stream of 144-byte Q4_K super-blocks into float32 values.
// ----------------------------------------------------------------------------
// header bytes: stored in the front end, no result
// nibble bytes: two values each, one per cycle while the result channel is ready
// value path: the queue, then the back end stages in order: scale times nibble,
// the two products, aligned subtract, leading one search and rounding
// reset: synchronous, clears byte position, queue and pipeline valids;
// header fields hold no reset value until written
module q4_k_block_dequantizer (
   input  wire logic    clock,
   input  wire logic    reset,
   q4kbd_req_if.sink    req_ch,
   q4kbd_rsp_if.source  rsp_ch
);

   q4kbd_pkg::push_type push;
   q4kbd_pkg::head_type head;
   logic full;
   logic pop;

   q4kbd_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .push   (push),
      .full   (full)
   );

   q4kbd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (full),
      .head  (head),
      .pop   (pop)
   );

   q4kbd_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule
`default_nettype wire
